// ----- hw/rtl/step_point_toward_target_defines.svh -----
// Assertion macros for the RTL; only step_point_toward_target.sv includes them.
// They expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef STEP_POINT_TOWARD_TARGET_DEFINES_SVH
`define STEP_POINT_TOWARD_TARGET_DEFINES_SVH

// Same-cycle implication.
`define SPTT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("step_point_toward_target: same-cycle check failed");

// Next-cycle implication.
`define SPTT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("step_point_toward_target: next-cycle check failed");

`endif

// ----- hw/rtl/sptt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sptt_pkg;

	localparam int unsigned CoordW = 32;
	localparam int unsigned DiffW  = CoordW + 1;
	localparam int unsigned SqW    = 2 * DiffW;
	localparam int unsigned RootW  = DiffW;
	localparam int unsigned CfgW   = 16;
	localparam int unsigned ProdW  = DiffW + CfgW;
	localparam int unsigned RemW   = RootW + 1;

	localparam logic [CfgW-1:0] STEP_RESET   = 16'd218;
	localparam logic [CfgW-1:0] ARRIVE_RESET = 16'd2621;

	typedef enum logic [1:0] {
		ST_RUNNING   = 2'd0,
		ST_SUCCEEDED = 2'd1,
		ST_FAILED    = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_STEP   = 1'b0,
		REG_ARRIVE = 1'b1
	} reg_idx_t;

	// Data that travels alongside the root and divider pipelines.
	typedef struct packed {
		logic                     ok;
		logic                     sx;
		logic                     sy;
		logic signed [CoordW-1:0] px;
		logic signed [CoordW-1:0] py;
		logic signed [CoordW-1:0] gx;
		logic signed [CoordW-1:0] gy;
		logic [DiffW-1:0]         ux;
		logic [DiffW-1:0]         uy;
		status_t                  status;
		logic                     tgt;
	} side_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sptt_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sptt_in_if;
	logic               valid;
	logic               ready;
	logic               has_position;
	logic               has_target;
	logic               target_has_position;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] goal_x;
	logic signed [31:0] goal_y;

	modport source (
		output valid, has_position, has_target, target_has_position,
		output pos_x, pos_y, goal_x, goal_y,
		input  ready
	);
	modport sink (
		input  valid, has_position, has_target, target_has_position,
		input  pos_x, pos_y, goal_x, goal_y,
		output ready
	);
endinterface

`default_nettype wire

// ----- hw/rtl/sptt_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sptt_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] new_x;
	logic signed [31:0] new_y;

	modport source (
		output valid, status, new_x, new_y,
		input  ready
	);
	modport sink (
		input  valid, status, new_x, new_y,
		output ready
	);
endinterface

`default_nettype wire

// ----- hw/rtl/sptt_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pipelined floored square root, one root bit per stage.
module sptt_sqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [sptt_pkg::SqW-1:0]      radicand,
	input  wire sptt_pkg::side_t               in_side,
	output logic                               out_valid,
	output logic [sptt_pkg::RootW-1:0]         root,
	output sptt_pkg::side_t                    out_side
);

	localparam int unsigned Steps = sptt_pkg::RootW;

	logic [Steps:0]                    v_s;
	logic [sptt_pkg::RemW-1:0]         rem_s  [0:Steps];
	logic [sptt_pkg::RootW-1:0]        rt_s   [0:Steps];
	logic [sptt_pkg::SqW-1:0]          rad_s  [0:Steps];
	sptt_pkg::side_t                   side_s [0:Steps];

	// Stage zero is the input itself.
	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign rt_s[0]   = '0;
	assign rad_s[0]  = radicand;
	assign side_s[0] = in_side;

	for (genvar k = 1; k <= Steps; k++) begin : g_stage
		logic [sptt_pkg::RemW:0] cur;
		logic [sptt_pkg::RemW:0] trial;
		logic                    take;

		// Bring down the next pair of radicand bits and try the next root bit.
		always_comb begin
			cur   = {rem_s[k-1][sptt_pkg::RemW-2:0], rad_s[k-1][sptt_pkg::SqW-1 -: 2]};
			trial = {1'b0, rt_s[k-1][sptt_pkg::RootW-2:0], 2'b01};
			take  = (cur >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? sptt_pkg::RemW'(cur - trial) : sptt_pkg::RemW'(cur);
				rt_s[k]   <= {rt_s[k-1][sptt_pkg::RootW-2:0], take};
				rad_s[k]  <= {rad_s[k-1][sptt_pkg::SqW-3:0], 2'b00};
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[Steps];
	assign root      = rt_s[Steps];
	assign out_side  = side_s[Steps];

endmodule

`default_nettype wire

// ----- hw/rtl/sptt_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider for both axes, one quotient bit per stage.
// The quotient is known to fit in DiffW bits, so the top numerator bits
// start out as the partial remainder.
module sptt_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [sptt_pkg::ProdW-1:0]    num_x,
	input  wire logic [sptt_pkg::ProdW-1:0]    num_y,
	input  wire logic [sptt_pkg::RootW-1:0]    divisor,
	input  wire sptt_pkg::side_t               in_side,
	output logic                               out_valid,
	output logic [sptt_pkg::DiffW-1:0]         quot_x,
	output logic [sptt_pkg::DiffW-1:0]         quot_y,
	output sptt_pkg::side_t                    out_side
);

	localparam int unsigned Steps = sptt_pkg::DiffW;
	localparam int unsigned W     = sptt_pkg::DiffW;

	logic [Steps:0]           v_s;
	logic [W-1:0]             rx_s   [0:Steps];
	logic [W-1:0]             ry_s   [0:Steps];
	logic [W-1:0]             nx_s   [0:Steps];
	logic [W-1:0]             ny_s   [0:Steps];
	logic [W-1:0]             qx_s   [0:Steps];
	logic [W-1:0]             qy_s   [0:Steps];
	logic [W-1:0]             d_s    [0:Steps];
	sptt_pkg::side_t          side_s [0:Steps];

	// One restoring step: returns the quotient bit over the new remainder.
	function automatic logic [W:0] div_step(input logic [W-1:0] rem, input logic nbit,
			input logic [W-1:0] d);
		logic [W:0] cur;
		logic       ge;
		cur = {rem, nbit};
		ge  = (cur >= {1'b0, d});
		return ge ? {1'b1, W'(cur - {1'b0, d})} : {1'b0, cur[W-1:0]};
	endfunction

	assign v_s[0]    = in_valid;
	assign rx_s[0]   = W'(num_x[sptt_pkg::ProdW-1:W]);
	assign ry_s[0]   = W'(num_y[sptt_pkg::ProdW-1:W]);
	assign nx_s[0]   = num_x[W-1:0];
	assign ny_s[0]   = num_y[W-1:0];
	assign qx_s[0]   = '0;
	assign qy_s[0]   = '0;
	assign d_s[0]    = divisor;
	assign side_s[0] = in_side;

	for (genvar k = 1; k <= Steps; k++) begin : g_stage
		logic [W:0] sx;
		logic [W:0] sy;

		always_comb begin
			sx = div_step(rx_s[k-1], nx_s[k-1][W-1], d_s[k-1]);
			sy = div_step(ry_s[k-1], ny_s[k-1][W-1], d_s[k-1]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[k]   <= sx[W-1:0];
				ry_s[k]   <= sy[W-1:0];
				qx_s[k]   <= {qx_s[k-1][W-2:0], sx[W]};
				qy_s[k]   <= {qy_s[k-1][W-2:0], sy[W]};
				nx_s[k]   <= {nx_s[k-1][W-2:0], 1'b0};
				ny_s[k]   <= {ny_s[k-1][W-2:0], 1'b0};
				d_s[k]    <= d_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[Steps];
	assign quot_x    = qx_s[Steps];
	assign quot_y    = qy_s[Steps];
	assign out_side  = side_s[Steps];

endmodule

`default_nettype wire

// ----- hw/rtl/step_point_toward_target.sv -----
// An accepted input beat passes 4 front stages, 33 root stages, 1 decision stage,
// 33 divider stages and 1 output register before it leaves as a result beat.
// Throughput: one beat per cycle while the output is not stalled; the root and
// divider pipelines each retire one bit a stage. A stalled output freezes the
// whole pipeline in place; nothing is dropped or repeated. Reset (arst_n low,
// asynchronous) clears all valid bits and loads step_size 218 and arrive_range 2621.
`timescale 1ns / 1ps
`default_nettype none
`include "step_point_toward_target_defines.svh"

module step_point_toward_target (
	input  wire logic              clk,
	input  wire logic              arst_n,
	sptt_in_if.sink                item,
	sptt_out_if.source             result,
	input  wire logic              cfg_we,
	input  wire logic [0:0]        cfg_idx,
	input  wire logic [15:0]       cfg_data
);

	localparam int unsigned CW = sptt_pkg::CoordW;
	localparam int unsigned DW = sptt_pkg::DiffW;

	logic [sptt_pkg::CfgW-1:0] step_q;
	logic [sptt_pkg::CfgW-1:0] arrive_q;
	logic                      en;

	logic                      v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	sptt_pkg::side_t           side_s1, side_s2, side_s3, side_s4, side_s5;
	sptt_pkg::side_t           side_c1, side_c2, side_c5;
	logic signed [DW-1:0]      dx_s1, dy_s1;
	logic [sptt_pkg::SqW-1:0]  sqx_s3, sqy_s3, sum_s4;
	logic [sptt_pkg::RootW-1:0] dist_s5;
	logic [sptt_pkg::ProdW-1:0] mx_s5, my_s5;

	logic                       v_r, v_d;
	logic [sptt_pkg::RootW-1:0] root_r;
	sptt_pkg::side_t            side_r, side_d;
	logic [DW-1:0]              qx_d, qy_d;

	sptt_pkg::status_t          status_s6;
	logic [CW-1:0]              nx_s6, ny_s6;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= sptt_pkg::STEP_RESET;
			arrive_q <= sptt_pkg::ARRIVE_RESET;
		end else if (cfg_we) begin
			unique case (sptt_pkg::reg_idx_t'(cfg_idx))
				sptt_pkg::REG_STEP:   step_q   <= cfg_data;
				sptt_pkg::REG_ARRIVE: arrive_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline advances unless the output register holds an untaken beat.
	assign en         = !v_s6 || result.ready;
	assign item.ready = en;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= item.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_r;
			v_s6 <= v_d;
		end
	end

	// Side data entering the first stage, and with the magnitudes for the second.
	always_comb begin
		side_c1     = '0;
		side_c1.ok  = item.has_position && item.has_target && item.target_has_position;
		side_c1.px  = item.pos_x;
		side_c1.py  = item.pos_y;
		side_c1.gx  = item.goal_x;
		side_c1.gy  = item.goal_y;

		side_c2     = side_s1;
		side_c2.sx  = dx_s1[DW-1];
		side_c2.sy  = dy_s1[DW-1];
		side_c2.ux  = dx_s1[DW-1] ? DW'(~dx_s1 + 1'b1) : DW'(dx_s1);
		side_c2.uy  = dy_s1[DW-1] ? DW'(~dy_s1 + 1'b1) : DW'(dy_s1);
	end

	// Front end: differences, magnitudes, squares and their sum.
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1        <= side_c1;
			dx_s1          <= {item.goal_x[CW-1], item.goal_x} - {item.pos_x[CW-1], item.pos_x};
			dy_s1          <= {item.goal_y[CW-1], item.goal_y} - {item.pos_y[CW-1], item.pos_y};

			side_s2        <= side_c2;

			side_s3        <= side_s2;
			sqx_s3         <= {{DW{1'b0}}, side_s2.ux} * {{DW{1'b0}}, side_s2.ux};
			sqy_s3         <= {{DW{1'b0}}, side_s2.uy} * {{DW{1'b0}}, side_s2.uy};

			side_s4        <= side_s3;
			sum_s4         <= sqx_s3 + sqy_s3;
		end
	end

	sptt_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.radicand  (sum_s4),
		.in_side   (side_s4),
		.out_valid (v_r),
		.root      (root_r),
		.out_side  (side_r)
	);

	// Classify the tick and note whether the step reaches the target.
	always_comb begin
		side_c5 = side_r;
		if (!side_r.ok) begin
			side_c5.status = sptt_pkg::ST_FAILED;
		end else if (root_r < {{(sptt_pkg::RootW - sptt_pkg::CfgW){1'b0}}, arrive_q}) begin
			side_c5.status = sptt_pkg::ST_SUCCEEDED;
		end else begin
			side_c5.status = sptt_pkg::ST_RUNNING;
		end
		side_c5.tgt = ({{(sptt_pkg::RootW - sptt_pkg::CfgW){1'b0}}, step_q} >= root_r);
	end

	// Decision stage: register the classification and scale the magnitudes by the step.
	always_ff @(posedge clk) begin
		if (en) begin
			side_s5     <= side_c5;
			dist_s5     <= root_r;
			mx_s5       <= {{sptt_pkg::CfgW{1'b0}}, side_r.ux} * {{DW{1'b0}}, step_q};
			my_s5       <= {{sptt_pkg::CfgW{1'b0}}, side_r.uy} * {{DW{1'b0}}, step_q};
		end
	end

	sptt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.num_x     (mx_s5),
		.num_y     (my_s5),
		.divisor   (dist_s5),
		.in_side   (side_s5),
		.out_valid (v_d),
		.quot_x    (qx_d),
		.quot_y    (qy_d),
		.out_side  (side_d)
	);

	// Output register: apply the step, snap to the target, or hold the position.
	always_ff @(posedge clk) begin
		if (en) begin
			status_s6 <= side_d.status;
			if (side_d.status != sptt_pkg::ST_RUNNING) begin
				nx_s6 <= side_d.px;
				ny_s6 <= side_d.py;
			end else if (side_d.tgt) begin
				nx_s6 <= side_d.gx;
				ny_s6 <= side_d.gy;
			end else begin
				nx_s6 <= side_d.sx ? side_d.px - qx_d[CW-1:0] : side_d.px + qx_d[CW-1:0];
				ny_s6 <= side_d.sy ? side_d.py - qy_d[CW-1:0] : side_d.py + qy_d[CW-1:0];
			end
		end
	end

	assign result.valid  = v_s6;
	assign result.status = status_s6;
	assign result.new_x  = nx_s6;
	assign result.new_y  = ny_s6;

	// A tick that did not run leaves the walker where it was.
	`SPTT_ASSERT_NEXT(a_hold_pos, en && v_d && side_d.status != sptt_pkg::ST_RUNNING, nx_s6 == $past(side_d.px) && ny_s6 == $past(side_d.py))
	// A partial step never moves farther than the gap on either axis.
	`SPTT_ASSERT_SAME(a_step_short, v_d && side_d.status == sptt_pkg::ST_RUNNING && !side_d.tgt, qx_d <= side_d.ux && qy_d <= side_d.uy)
	// A beat leaving the root pipeline reaches the decision stage.
	`SPTT_ASSERT_NEXT(a_root_to_dec, en && v_r, v_s5)

endmodule

`default_nettype wire

// ----- dv/tb_chan_if.sv -----
`timescale 1ns / 1ps

// Interfaces come from the RTL (sptt_in_if, sptt_out_if); this file holds the
// beat records that the testbench moves through them.
package tb_beat_pkg;
	import sptt_pkg::*;

	typedef struct {
		logic               has_position;
		logic               has_target;
		logic               target_has_position;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] goal_x;
		logic signed [31:0] goal_y;
	} walk_req_t;

	typedef struct {
		status_t            status;
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
	} walk_res_t;
endpackage

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

// Scoreboard: predicts each step and holds the expected results in order.
class walk_scoreboard;
	tb_beat_pkg::walk_res_t pending[$];
	logic [15:0] step_size;
	logic [15:0] arrive_range;
	int errors;

	function new();
		step_size = sptt_pkg::STEP_RESET;
		arrive_range = sptt_pkg::ARRIVE_RESET;
		errors = 0;
	endfunction

	// Floored square root of a 66-bit sum of squares, one bit at a time.
	function logic [33:0] floor_root(logic [65:0] sq);
		logic [33:0] r;
		logic [33:0] c;
		r = '0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (34'd1 << b);
			if ({34'd0, c} * {34'd0, c} <= {2'b0, sq}) r = c;
		end
		return r;
	endfunction

	function logic signed [31:0] nudge(logic signed [63:0] p, logic signed [63:0] d,
			logic [33:0] gap_len);
		logic [63:0] mag;
		logic [63:0] q;
		mag = d < 0 ? -d : d;
		q = (mag * step_size) / gap_len;
		return d < 0 ? p - $signed(q) : p + $signed(q);
	endfunction

	function void note_request(tb_beat_pkg::walk_req_t r);
		tb_beat_pkg::walk_res_t e;
		logic signed [63:0] dx, dy;
		logic [63:0] ux, uy;
		logic [33:0] gap_len;
		e.status = sptt_pkg::ST_FAILED;
		e.new_x = r.pos_x;
		e.new_y = r.pos_y;
		if (r.has_position && r.has_target && r.target_has_position) begin
			dx = 64'(r.goal_x) - 64'(r.pos_x);
			dy = 64'(r.goal_y) - 64'(r.pos_y);
			ux = dx < 0 ? -dx : dx;
			uy = dy < 0 ? -dy : dy;
			gap_len = floor_root(66'(ux) * 66'(ux) + 66'(uy) * 66'(uy));
			if (gap_len < arrive_range) begin
				e.status = sptt_pkg::ST_SUCCEEDED;
			end else begin
				e.status = sptt_pkg::ST_RUNNING;
				if (step_size >= gap_len) begin
					e.new_x = r.goal_x;
					e.new_y = r.goal_y;
				end else begin
					e.new_x = nudge(r.pos_x, dx, gap_len);
					e.new_y = nudge(r.pos_y, dy, gap_len);
				end
			end
		end
		pending.push_back(e);
	endfunction

	function void check_result(logic [1:0] st, logic [31:0] nx, logic [31:0] ny);
		tb_beat_pkg::walk_res_t e;
		if (pending.size() == 0) begin
			$error("result beat with nothing expected");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (st !== e.status) begin
			$error("status: expected %0d, got %0d", e.status, st);
			errors++;
		end
		if (nx !== e.new_x) begin
			$error("new_x: expected %h, got %h", e.new_x, nx);
			errors++;
		end
		if (ny !== e.new_y) begin
			$error("new_y: expected %h, got %h", e.new_y, ny);
			errors++;
		end
	endfunction
endclass

module testbench;
	import sptt_pkg::*;
	import tb_beat_pkg::*;

	localparam int Latency = 72;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_idx = REG_STEP;
	logic [15:0] cfg_data = '0;
	int hold_off = 0;
	bit random_stall = 0;

	sptt_in_if item ();
	sptt_out_if result ();

	walk_scoreboard board = new();

	step_point_toward_target dut (
		.clk(clk), .arst_n(arst_n), .item(item.sink), .result(result.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		item.valid = 1'b0;
		item.has_position = 1'b0;
		item.has_target = 1'b0;
		item.target_has_position = 1'b0;
		item.pos_x = '0;
		item.pos_y = '0;
		item.goal_x = '0;
		item.goal_y = '0;
		result.ready = 1'b0;
	end

	// Both beats are sampled at the rising edge.
	always @(posedge clk) begin
		walk_req_t r;
		if (arst_n && item.valid && item.ready) begin
			r.has_position = item.has_position;
			r.has_target = item.has_target;
			r.target_has_position = item.target_has_position;
			r.pos_x = item.pos_x;
			r.pos_y = item.pos_y;
			r.goal_x = item.goal_x;
			r.goal_y = item.goal_y;
			board.note_request(r);
		end
		if (arst_n && result.valid && result.ready)
			board.check_result(result.status, result.new_x, result.new_y);
	end

	// Receiver: a long hold-off when asked, otherwise a random stall pattern when enabled, else always ready.
	always @(negedge clk) begin
		if (hold_off > 0) begin
			result.ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else if (random_stall) begin
			result.ready <= ($urandom_range(0, 3) != 0);
		end else begin
			result.ready <= 1'b1;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		board.step_size = (idx == REG_STEP) ? val : board.step_size;
		board.arrive_range = (idx == REG_ARRIVE) ? val : board.arrive_range;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send(walk_req_t r);
		item.valid = 1'b1;
		item.has_position = r.has_position;
		item.has_target = r.has_target;
		item.target_has_position = r.target_has_position;
		item.pos_x = r.pos_x;
		item.pos_y = r.pos_y;
		item.goal_x = r.goal_x;
		item.goal_y = r.goal_y;
		do @(posedge clk); while (!item.ready);
		@(negedge clk);
	endtask

	task automatic pause_sender();
		item.valid = 1'b0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	task automatic drain();
		item.valid = 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (Latency + 8) @(negedge clk);
	endtask

	function automatic walk_req_t pick_random();
		walk_req_t r;
		int unsigned span;
		r.has_position = ($urandom_range(0, 9) != 0);
		r.has_target = ($urandom_range(0, 9) != 0);
		r.target_has_position = ($urandom_range(0, 9) != 0);
		r.pos_x = $urandom;
		r.pos_y = $urandom;
		case ($urandom_range(0, 3))
			0: begin
				r.goal_x = $urandom;
				r.goal_y = $urandom;
			end
			default: begin
				// Near targets so arrival and short moves come up often.
				span = 1 << $urandom_range(0, 20);
				r.goal_x = r.pos_x + $signed($urandom_range(0, 2 * span)) - $signed(span);
				r.goal_y = r.pos_y + $signed($urandom_range(0, 2 * span)) - $signed(span);
			end
		endcase
		return r;
	endfunction

	function automatic walk_req_t mk(logic [2:0] f, int px, int py, int gx, int gy);
		walk_req_t r;
		{r.has_position, r.has_target, r.target_has_position} = f;
		r.pos_x = px;
		r.pos_y = py;
		r.goal_x = gx;
		r.goal_y = gy;
		return r;
	endfunction

	initial begin
		walk_req_t dir[$];
		logic [15:0] steps[4] = '{16'd0, 16'd65535, 16'd1, 16'd4000};
		logic [15:0] ranges[4] = '{16'd65535, 16'd0, 16'd1, 16'd2621};
		int quarter;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: missing flags, extremes, arrival, step past the target.
		dir.push_back(mk(3'b011, 1, 2, 3, 4));
		dir.push_back(mk(3'b101, 1, 2, 3, 4));
		dir.push_back(mk(3'b110, 1, 2, 3, 4));
		dir.push_back(mk(3'b000, -1, -1, 0, 0));
		dir.push_back(mk(3'b111, 0, 0, 0, 0));
		dir.push_back(mk(3'b111, 0, 0, 100, 0));
		dir.push_back(mk(3'b111, 0, 0, 65536, 65536));
		dir.push_back(mk(3'b111, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
		dir.push_back(mk(3'b111, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000));
		dir.push_back(mk(3'b111, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff));
		dir.push_back(mk(3'b111, 0, 0, 2620, 0));
		dir.push_back(mk(3'b111, 0, 0, 2621, 0));
		dir.push_back(mk(3'b111, 0, 0, 0, -200));
		dir.push_back(mk(3'b111, 5, 5, 5, 5 + 218));
		dir.push_back(mk(3'b111, -70000, 3000, 70000, -3000));
		foreach (dir[i]) send(dir[i]);
		drain();

		// Four random phases, each under its own register setting.
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_STEP, ph == 3 ? 16'($urandom) : steps[ph]);
			write_reg(REG_ARRIVE, ph == 3 ? 16'($urandom) : ranges[ph]);
			random_stall = (ph != 0);
			quarter = 0;
			while (quarter < 235) begin
				repeat ($urandom_range(1, 12)) begin
					if (quarter < 235) begin
						if (ph == 1 && quarter == 100) hold_off = 300;
						send(pick_random());
						quarter++;
					end
				end
				if ($urandom_range(0, 1)) pause_sender();
			end
			drain();
		end

		if (board.errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("Some tests failed");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/sptt_pkg.sv
hw/rtl/sptt_in_if.sv
hw/rtl/sptt_out_if.sv
hw/rtl/sptt_sqrt.sv
hw/rtl/sptt_div.sv
hw/rtl/step_point_toward_target.sv
dv/tb_chan_if.sv
dv/testbench.sv
